// ----- rtl/core/sts_pkg.sv -----
package sts_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);

  // token kinds
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_ERROR   = 4'd1;
  localparam logic [3:0] K_SPACE   = 4'd2;
  localparam logic [3:0] K_IDENT   = 4'd3;
  localparam logic [3:0] K_BOOL    = 4'd4;
  localparam logic [3:0] K_CHAR    = 4'd5;
  localparam logic [3:0] K_INT     = 4'd6;
  localparam logic [3:0] K_FLOAT   = 4'd7;
  localparam logic [3:0] K_STRING  = 4'd8;
  localparam logic [3:0] K_OPEN    = 4'd9;
  localparam logic [3:0] K_CLOSE   = 4'd10;
  localparam logic [3:0] K_QUOTE   = 4'd11;
  localparam logic [3:0] K_COMMENT = 4'd12;

  // special bytes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } res_t;

  // results raised by one byte: up to two, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } emit_t;

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_sym_first(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2F, 8'h3A, 8'h3C,
      8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic ident_first(input logic [7:0] c);
    return is_alpha(c) || is_sym_first(c);
  endfunction

  function automatic logic ident_next(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_sym_first(c) || (c == CH_DOT);
  endfunction

endpackage

// ----- rtl/core/sts_scan.sv -----
module sts_scan #(
  parameter int unsigned CountBits = sts_pkg::COUNT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     ch_i,
  output sts_pkg::emit_t emit_o
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_SPACE   = 12'b0000_0000_0010,
    ST_IDENT   = 12'b0000_0000_0100,
    ST_SIGN    = 12'b0000_0000_1000,
    ST_INT     = 12'b0000_0001_0000,
    ST_FLOAT   = 12'b0000_0010_0000,
    ST_STRING  = 12'b0000_0100_0000,
    ST_HASH    = 12'b0000_1000_0000,
    ST_BOOL    = 12'b0001_0000_0000,
    ST_CHSLASH = 12'b0010_0000_0000,
    ST_CHNAME  = 12'b0100_0000_0000,
    ST_COMMENT = 12'b1000_0000_0000
  } state_e;

  typedef logic [CountBits-1:0] cnt_t;

  state_e     state_q, state_d;
  logic [3:0] kind_q, kind_d;
  cnt_t       len_q, len_d;
  cnt_t       pline_q, pline_d;
  cnt_t       pcol_q, pcol_d;
  cnt_t       line_q, line_d;
  cnt_t       col_q, col_d;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] to16(input cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  logic       cont, close, pend_emit, start_emit, single;
  state_e     cont_state, start_state;
  logic [3:0] cont_kind, start_kind;
  cnt_t       adv_line, adv_col;
  sts_pkg::res_t res_a, res_b;

  assign adv_line = (ch_i == sts_pkg::CH_LF) ? sat_inc(line_q) : line_q;
  assign adv_col  = (ch_i == sts_pkg::CH_LF) ? '0 : sat_inc(col_q);

  // continuation of the token under way
  always_comb begin
    cont       = 1'b0;
    close      = 1'b0;
    cont_state = state_q;
    cont_kind  = kind_q;
    unique case (state_q)
      ST_IDLE:  ;
      ST_SPACE: cont = sts_pkg::is_space(ch_i);
      ST_IDENT: cont = sts_pkg::ident_next(ch_i);
      ST_SIGN: begin
        if (sts_pkg::is_digit(ch_i)) begin
          cont_kind  = sts_pkg::K_INT;
          cont_state = ST_INT;
          cont       = 1'b1;
        end else if (sts_pkg::ident_next(ch_i)) begin
          cont_state = ST_IDENT;
          cont       = 1'b1;
        end
      end
      ST_INT: begin
        if (ch_i == sts_pkg::CH_DOT) begin
          cont_kind  = sts_pkg::K_FLOAT;
          cont_state = ST_FLOAT;
          cont       = 1'b1;
        end else begin
          cont = sts_pkg::is_digit(ch_i);
        end
      end
      ST_FLOAT: cont = sts_pkg::is_digit(ch_i);
      ST_STRING: begin
        if (ch_i == sts_pkg::CH_DQUOTE) close = 1'b1;
        else cont = (ch_i != sts_pkg::CH_NUL);
      end
      ST_HASH: begin
        if ((ch_i == sts_pkg::CH_T) || (ch_i == sts_pkg::CH_F)) begin
          cont_kind  = sts_pkg::K_BOOL;
          cont_state = ST_BOOL;
          cont       = 1'b1;
        end else if (ch_i == sts_pkg::CH_BSLASH) begin
          cont_kind  = sts_pkg::K_CHAR;
          cont_state = ST_CHSLASH;
          cont       = 1'b1;
        end
      end
      ST_BOOL: cont = sts_pkg::is_alpha(ch_i);
      ST_CHSLASH: begin
        if (ch_i != sts_pkg::CH_NUL) begin
          cont_state = ST_CHNAME;
          cont       = 1'b1;
        end
      end
      ST_CHNAME: cont = sts_pkg::is_alpha(ch_i);
      ST_COMMENT: begin
        if (ch_i == sts_pkg::CH_LF) close = 1'b1;
        else cont = (ch_i != sts_pkg::CH_NUL);
      end
      default: cont_state = ST_IDLE;
    endcase
  end

  // classify a byte that opens a new token
  always_comb begin
    start_kind  = sts_pkg::K_ERROR;
    start_state = ST_IDLE;
    single      = 1'b0;
    if (sts_pkg::is_space(ch_i)) begin
      start_kind  = sts_pkg::K_SPACE;
      start_state = ST_SPACE;
    end else if (sts_pkg::ident_first(ch_i)) begin
      start_kind  = sts_pkg::K_IDENT;
      start_state = ST_IDENT;
    end else if (sts_pkg::is_digit(ch_i)) begin
      start_kind  = sts_pkg::K_INT;
      start_state = ST_INT;
    end else if ((ch_i == sts_pkg::CH_PLUS) || (ch_i == sts_pkg::CH_MINUS)) begin
      start_kind  = sts_pkg::K_IDENT;
      start_state = ST_SIGN;
    end else if (ch_i == sts_pkg::CH_DQUOTE) begin
      start_kind  = sts_pkg::K_STRING;
      start_state = ST_STRING;
    end else if (ch_i == sts_pkg::CH_HASH) begin
      start_kind  = sts_pkg::K_ERROR;
      start_state = ST_HASH;
    end else if (ch_i == sts_pkg::CH_SEMI) begin
      start_kind  = sts_pkg::K_COMMENT;
      start_state = ST_COMMENT;
    end else begin
      single = 1'b1;
      if (ch_i == sts_pkg::CH_LPAREN)      start_kind = sts_pkg::K_OPEN;
      else if (ch_i == sts_pkg::CH_RPAREN) start_kind = sts_pkg::K_CLOSE;
      else if (ch_i == sts_pkg::CH_SQUOTE) start_kind = sts_pkg::K_QUOTE;
      else                                 start_kind = sts_pkg::K_ERROR;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    len_d      = len_q;
    pline_d    = pline_q;
    pcol_d     = pcol_q;
    line_d     = line_q;
    col_d      = col_q;
    pend_emit  = 1'b0;
    start_emit = 1'b0;
    res_a      = '{kind: kind_q, length: to16(len_q), line: to16(pline_q),
                   column: to16(pcol_q), last: 1'b0};
    res_b      = '{kind: start_kind, length: 16'd1, line: to16(line_q),
                   column: to16(col_q), last: 1'b1};
    if (cont) begin
      state_d = cont_state;
      kind_d  = cont_kind;
      len_d   = sat_inc(len_q);
      line_d  = adv_line;
      col_d   = adv_col;
    end else if (close) begin
      // closing byte belongs to the token
      pend_emit    = 1'b1;
      res_a.length = to16(sat_inc(len_q));
      state_d      = ST_IDLE;
      len_d        = sat_inc(len_q);
      line_d       = adv_line;
      col_d        = adv_col;
    end else begin
      pend_emit = (state_q != ST_IDLE);
      state_d   = ST_IDLE;
      if (ch_i == sts_pkg::CH_NUL) begin
        start_emit   = 1'b1;
        res_b.kind   = sts_pkg::K_END;
        res_b.length = 16'd0;
        line_d       = '0;
        col_d        = '0;
      end else begin
        kind_d     = start_kind;
        len_d      = cnt_t'(1);
        pline_d    = line_q;
        pcol_d     = col_q;
        line_d     = adv_line;
        col_d      = adv_col;
        start_emit = single;
        if (!single) state_d = start_state;
      end
    end
  end

  always_comb begin
    emit_o.cnt = {1'b0, pend_emit} + {1'b0, start_emit};
    emit_o.r1  = res_b;
    if (pend_emit) begin
      emit_o.r0      = res_a;
      emit_o.r0.last = !start_emit;
    end else begin
      emit_o.r0 = res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= '0;
      len_q   <= '0;
      pline_q <= '0;
      pcol_q  <= '0;
      line_q  <= '0;
      col_q   <= '0;
    end else if (take_i) begin
      state_q <= state_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      pline_q <= pline_d;
      pcol_q  <= pcol_d;
      line_q  <= line_d;
      col_q   <= col_d;
    end
  end

endmodule

// ----- rtl/core/sts_fifo.sv -----
module sts_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  sts_pkg::emit_t                  emit_i,
  output logic                            full_o,
  output logic                            valid_o,
  input  logic                            pop_i,
  output sts_pkg::res_t                   data_o,
  output logic [sts_pkg::PTR_BITS:0]      count_o
);

  localparam int unsigned PtrBits = sts_pkg::PTR_BITS;

  sts_pkg::res_t              mem_q [sts_pkg::FIFO_DEPTH];
  logic [PtrBits-1:0]         wptr_q, rptr_q;
  logic [PtrBits:0]           count_q;
  logic [PtrBits:0]           push_n;
  logic                       pop;

  assign push_n  = push_i ? (PtrBits+1)'(emit_i.cnt) : '0;
  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;
  // keep room for a two-beat burst
  assign full_o  = (count_q > (PtrBits+1)'(sts_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i && (emit_i.cnt != 2'd0)) mem_q[wptr_q] <= emit_i.r0;
    if (push_i && (emit_i.cnt == 2'd2)) mem_q[wptr_q + 1'b1] <= emit_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + push_n[PtrBits-1:0];
      rptr_q  <= rptr_q + PtrBits'(pop);
      count_q <= count_q + push_n - (PtrBits+1)'(pop);
    end
  end

endmodule

// ----- rtl/core/sexpr_token_scanner_top.sv -----
// Streaming lexer for Scheme text: one byte enters per beat, and each completed token
// leaves as one result beat with its kind, length and start line/column (saturating).
// A byte is scanned in the cycle it is accepted, so a steady stream runs at one byte
// per clock. A byte that closes one token and forms another raises two results; these
// queue in a four-entry result buffer that drains one beat per clock unless out_stall_i
// is high, and input stalls only while that buffer cannot hold two more results. A zero
// byte flushes any open token, emits an end token and returns the coordinates to zero.
module sexpr_token_scanner_top #(
  parameter int unsigned COUNT_BITS = sts_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [15:0] token_length_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic        last_o
);

  logic                          take;
  sts_pkg::emit_t                emit;
  sts_pkg::res_t                 head;
  logic                          full;
  logic [sts_pkg::PTR_BITS:0]    count;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  sts_scan #(
    .CountBits (COUNT_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (ch_i),
    .emit_o (emit)
  );

  sts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .emit_i  (emit),
    .full_o  (full),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .data_o  (head),
    .count_o (count)
  );

  assign kind_o         = head.kind;
  assign token_length_o = head.length;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign last_o         = head.last;

  // the queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= (sts_pkg::PTR_BITS+1)'(sts_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // an accepted end byte always yields a result beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (ch_i == sts_pkg::CH_NUL)) |=> out_valid_o)
    else $error("end byte produced no result");

  // the first beat of a pair is always followed by its partner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("second result of a pair missing");

  // delivered kinds stay within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o <= sts_pkg::K_COMMENT))
    else $error("undefined token kind delivered");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned PHASE_BYTES  = 583;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef enum logic [3:0] {
    LX_IDLE, LX_SPACE, LX_IDENT, LX_SIGN, LX_INT, LX_FLOAT, LX_STRING,
    LX_HASH, LX_BOOL, LX_CHSLASH, LX_CHNAME, LX_COMMENT
  } lex_state_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       pinned;
    token_t     pin;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_pinned = 1'b0;
  token_t      in_pin = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  kind;
  logic [15:0] tok_len;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic        tok_last;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  string letters_s = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string digits_s  = "0123456789";
  string sym_head_s = "!$%&*/:<=>?@^_~";
  string sym_tail_s = "!$%&*./:<=>?@^_~";
  string blanks_s  = "\011\012\013\014\015\040";

  // scanner model state
  lex_state_e  lx_state;
  logic [3:0]  p_kind;
  logic [15:0] p_len, p_line, p_col, cur_line, cur_col;
  token_t      step_q[$];
  token_t      tok_expect_q[$];
  dir_row_t    dir_tab[$];

  sexpr_token_scanner_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .ch_i           (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .token_length_o (tok_len),
    .start_line_o   (tok_line),
    .start_column_o (tok_col),
    .last_o         (tok_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- model
  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic in_str(input logic [7:0] c, input string s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (s[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic word_head(input logic [7:0] c);
    return is_letter(c) || in_str(c, sym_head_s);
  endfunction

  function automatic logic word_tail(input logic [7:0] c);
    return is_letter(c) || is_num(c) || in_str(c, sym_tail_s);
  endfunction

  task automatic note_token(input logic [3:0] k, input logic [15:0] n,
                            input logic [15:0] l, input logic [15:0] c);
    token_t t;
    t.kind = k;
    t.len  = n;
    t.line = l;
    t.col  = c;
    t.last = 1'b0;
    step_q.push_back(t);
  endtask

  task automatic take_byte(input logic [7:0] c);
    p_len = sat16(p_len);
    if (c == sts_pkg::CH_LF) begin
      cur_line = sat16(cur_line);
      cur_col  = '0;
    end else begin
      cur_col = sat16(cur_col);
    end
  endtask

  task automatic open_token(input logic [3:0] k, input logic [7:0] c);
    p_kind = k;
    p_len  = '0;
    p_line = cur_line;
    p_col  = cur_col;
    take_byte(c);
  endtask

  task automatic flush_token();
    note_token(p_kind, p_len, p_line, p_col);
    lx_state = LX_IDLE;
  endtask

  task automatic start_token(input logic [7:0] c);
    logic [3:0] k;
    if (c == sts_pkg::CH_NUL) begin
      note_token(sts_pkg::K_END, '0, cur_line, cur_col);
      cur_line = '0;
      cur_col  = '0;
      lx_state = LX_IDLE;
    end else if (is_ws(c)) begin
      open_token(sts_pkg::K_SPACE, c);
      lx_state = LX_SPACE;
    end else if (word_head(c)) begin
      open_token(sts_pkg::K_IDENT, c);
      lx_state = LX_IDENT;
    end else if (is_num(c)) begin
      open_token(sts_pkg::K_INT, c);
      lx_state = LX_INT;
    end else if (c == sts_pkg::CH_PLUS || c == sts_pkg::CH_MINUS) begin
      open_token(sts_pkg::K_IDENT, c);
      lx_state = LX_SIGN;
    end else if (c == sts_pkg::CH_DQUOTE) begin
      open_token(sts_pkg::K_STRING, c);
      lx_state = LX_STRING;
    end else if (c == sts_pkg::CH_HASH) begin
      open_token(sts_pkg::K_ERROR, c);
      lx_state = LX_HASH;
    end else if (c == sts_pkg::CH_SEMI) begin
      open_token(sts_pkg::K_COMMENT, c);
      lx_state = LX_COMMENT;
    end else begin
      k = (c == sts_pkg::CH_LPAREN) ? sts_pkg::K_OPEN :
          (c == sts_pkg::CH_RPAREN) ? sts_pkg::K_CLOSE :
          (c == sts_pkg::CH_SQUOTE) ? sts_pkg::K_QUOTE : sts_pkg::K_ERROR;
      open_token(k, c);
      flush_token();
    end
  endtask

  // advance the scanner model by one byte; tokens land in step_q
  task automatic lex_step(input logic [7:0] c);
    logic grow, shut;
    grow = 1'b0;
    shut = 1'b0;
    case (lx_state)
      LX_SPACE: grow = is_ws(c);
      LX_IDENT: grow = word_tail(c);
      LX_SIGN: begin
        if (is_num(c)) begin
          p_kind = sts_pkg::K_INT;
          lx_state = LX_INT;
          grow = 1'b1;
        end else if (word_tail(c)) begin
          lx_state = LX_IDENT;
          grow = 1'b1;
        end
      end
      LX_INT: begin
        if (c == sts_pkg::CH_DOT) begin
          p_kind = sts_pkg::K_FLOAT;
          lx_state = LX_FLOAT;
          grow = 1'b1;
        end else begin
          grow = is_num(c);
        end
      end
      LX_FLOAT: grow = is_num(c);
      LX_STRING: begin
        if (c == sts_pkg::CH_DQUOTE) shut = 1'b1;
        else grow = (c != sts_pkg::CH_NUL);
      end
      LX_HASH: begin
        if (c == sts_pkg::CH_T || c == sts_pkg::CH_F) begin
          p_kind = sts_pkg::K_BOOL;
          lx_state = LX_BOOL;
          grow = 1'b1;
        end else if (c == sts_pkg::CH_BSLASH) begin
          p_kind = sts_pkg::K_CHAR;
          lx_state = LX_CHSLASH;
          grow = 1'b1;
        end
      end
      LX_BOOL: grow = is_letter(c);
      LX_CHSLASH: begin
        if (c != sts_pkg::CH_NUL) begin
          lx_state = LX_CHNAME;
          grow = 1'b1;
        end
      end
      LX_CHNAME: grow = is_letter(c);
      LX_COMMENT: begin
        if (c == sts_pkg::CH_LF) shut = 1'b1;
        else grow = (c != sts_pkg::CH_NUL);
      end
      default: lx_state = LX_IDLE;
    endcase

    if (grow) begin
      take_byte(c);
    end else if (shut) begin
      take_byte(c);
      flush_token();
    end else begin
      if (lx_state != LX_IDLE) flush_token();
      start_token(c);
    end
  endtask

  // ------------------------------------------------------------ checking
  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : tok_check
    token_t t;
    if (!rst_n) begin
      lx_state = LX_IDLE;
      p_kind   = sts_pkg::K_END;
      p_len    = '0;
      p_line   = '0;
      p_col    = '0;
      cur_line = '0;
      cur_col  = '0;
      step_q.delete();
      tok_expect_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        step_q.delete();
        lex_step(in_byte);
        if (step_q.size() != 0) begin
          t = step_q.pop_back();
          t.last = 1'b1;
          step_q.push_back(in_pinned ? in_pin : t);
        end
        while (step_q.size() != 0) tok_expect_q.push_back(step_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (tok_expect_q.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d len %0d at %0d:%0d",
                   $time, kind, tok_len, tok_line, tok_col);
          errors++;
        end else begin
          t = tok_expect_q.pop_front();
          check_field("kind", 16'(t.kind), 16'(kind));
          check_field("token_length", t.len, tok_len);
          check_field("start_line", t.line, tok_line);
          check_field("start_column", t.col, tok_col);
          check_field("last", 16'(t.last), 16'(tok_last));
        end
      end
    end
  end

  // ------------------------------------------------------------ stimulus
  task automatic push_byte(input logic [7:0] b, input logic pinned, input token_t pin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    in_pinned <= pinned;
    in_pin    <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put(input logic [7:0] b);
    push_byte(b, 1'b0, '0);
  endtask

  task automatic dir_add(input logic [7:0] c, input logic pinned, input logic [3:0] k,
                         input logic [15:0] n, input logic [15:0] l, input logic [15:0] col);
    dir_row_t r;
    r.ch       = c;
    r.pinned   = pinned;
    r.pin.kind = k;
    r.pin.len  = n;
    r.pin.line = l;
    r.pin.col  = col;
    r.pin.last = 1'b1;
    dir_tab.push_back(r);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == x);
    return b;
  endfunction

  // one mostly well-formed lexeme with random content, some broken
  task automatic send_lexeme();
    int unsigned sel, n;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) put(pick(blanks_s));
    end else if (sel < 30) begin
      put(pick({letters_s, sym_head_s}));
      n = $urandom_range(0, 5);
      repeat (n) put(pick({letters_s, digits_s, sym_tail_s}));
    end else if (sel < 38) begin
      put($urandom_range(0, 1) ? sts_pkg::CH_PLUS : sts_pkg::CH_MINUS);
      n = $urandom_range(0, 9);
      if (n < 4) begin
        repeat (n + 1) put(pick(digits_s));
      end else if (n < 7) begin
        repeat (n - 3) put(pick({letters_s, digits_s, sym_tail_s}));
      end
    end else if (sel < 52) begin
      n = $urandom_range(1, 4);
      repeat (n) put(pick(digits_s));
      if ($urandom_range(0, 9) < 4) begin
        put(sts_pkg::CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) put(pick(digits_s));
      end
    end else if (sel < 60) begin
      put(sts_pkg::CH_DQUOTE);
      n = $urandom_range(0, 6);
      repeat (n) put(any_but(sts_pkg::CH_DQUOTE));
      if ($urandom_range(0, 99) < 85) put(sts_pkg::CH_DQUOTE);
    end else if (sel < 66) begin
      put(sts_pkg::CH_HASH);
      if ($urandom_range(0, 9) < 7) begin
        put($urandom_range(0, 1) ? sts_pkg::CH_T : sts_pkg::CH_F);
        n = $urandom_range(0, 3);
        repeat (n) put(pick(letters_s));
      end else begin
        // broken hash: a random next byte, which mostly starts afresh
        put(8'($urandom_range(0, 255)));
      end
    end else if (sel < 72) begin
      put(sts_pkg::CH_HASH);
      put(sts_pkg::CH_BSLASH);
      put(8'($urandom_range(1, 255)));
      n = $urandom_range(0, 3);
      repeat (n) put(pick(letters_s));
    end else if (sel < 78) begin
      put(sts_pkg::CH_SEMI);
      n = $urandom_range(0, 6);
      repeat (n) put(any_but(sts_pkg::CH_LF));
      if ($urandom_range(0, 99) < 85) put(sts_pkg::CH_LF);
    end else if (sel < 90) begin
      n = $urandom_range(0, 2);
      put((n == 0) ? sts_pkg::CH_LPAREN : (n == 1) ? sts_pkg::CH_RPAREN : sts_pkg::CH_SQUOTE);
    end else if (sel < 97) begin
      put(8'($urandom_range(1, 255)));
    end else begin
      put(sts_pkg::CH_NUL);
    end
  endtask

  initial begin : stimulus
    int unsigned target, drain;

    // directed: every class but a plain integer, hash repairs, end of text with open tokens
    dir_add(sts_pkg::CH_LPAREN, 1'b1, sts_pkg::K_OPEN, 16'd1, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_RPAREN, 1'b1, sts_pkg::K_CLOSE, 16'd1, 16'd0, 16'd1);
    dir_add(sts_pkg::CH_SQUOTE, 1'b1, sts_pkg::K_QUOTE, 16'd1, 16'd0, 16'd2);
    dir_add(8'h01, 1'b1, sts_pkg::K_ERROR, 16'd1, 16'd0, 16'd3);
    dir_add(8'hFF, 1'b1, sts_pkg::K_ERROR, 16'd1, 16'd0, 16'd4);
    dir_add(sts_pkg::CH_HASH, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_LPAREN, 1'b1, sts_pkg::K_OPEN, 16'd1, 16'd0, 16'd6);
    dir_add(sts_pkg::CH_HASH, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_T, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add("r", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_BSLASH, 1'b1, sts_pkg::K_ERROR, 16'd1, 16'd0, 16'd10);
    dir_add(sts_pkg::CH_HASH, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_BSLASH, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_RPAREN, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add("a", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(" ", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_MINUS, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add("5", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_DOT, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add("7", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_DQUOTE, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_LF, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_DQUOTE, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_SEMI, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add("q", 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_LF, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_DQUOTE, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_NUL, 1'b1, sts_pkg::K_END, 16'd0, 16'd2, 16'd1);
    dir_add(sts_pkg::CH_PLUS, 1'b0, sts_pkg::K_END, 16'd0, 16'd0, 16'd0);
    dir_add(sts_pkg::CH_NUL, 1'b1, sts_pkg::K_END, 16'd0, 16'd0, 16'd1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 6;
    rx_idle_pct = 65;
    foreach (dir_tab[i]) push_byte(dir_tab[i].ch, dir_tab[i].pinned, dir_tab[i].pin);
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_lexeme();

    tx_idle_pct = 65;
    rx_idle_pct = 6;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_lexeme();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_lexeme();
    put(sts_pkg::CH_NUL);

    in_valid <= 1'b0;
    drain = 0;
    while (tok_expect_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (tok_expect_q.size() != 0) begin
      $display("%0t: %0d expected tokens outstanding, expected 0, got %0d", $time,
               tok_expect_q.size(), tok_expect_q.size());
      errors++;
    end
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
